FILE: hw/rtl/smef_pkg.sv
`timescale 1ns / 1ps
// Shared codes, types and fade arithmetic for the marquee block.
package smef_pkg;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BG_RED         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BG_GREEN       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG_BLUE        = 3'd5;

	localparam logic [10:0] TEXT_WIDTH_RST    = 11'd100;
	localparam logic [10:0] DISPLAY_WIDTH_RST = 11'd100;

	localparam logic [4:0] FADE_SPAN   = 5'd24;
	localparam int         QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [12:0] red;
		logic [12:0] green;
		logic [12:0] blue;
	} sum3_t;

	// one queued request: a store write or a display read
	typedef struct packed {
		logic       is_read;
		logic       hit;
		rgb_t       pixel;
		logic       fade_l;
		logic [4:0] w_l;
		logic       fade_r;
		logic [4:0] w_r;
	} entry_t;

	function automatic logic [12:0] fade_sum(input logic [7:0] p, input logic [7:0] bg,
			input logic [4:0] w);
		logic [12:0] a;
		logic [12:0] b;
		a = 13'(w) * 13'(p);
		b = 13'(FADE_SPAN - w) * 13'(bg);
		return a + b;
	endfunction

	// v/24 = (v>>3)/3, and /3 is *683>>11, exact for v>>3 below 1536
	function automatic logic [7:0] div24(input logic [12:0] v);
		logic [19:0] prod;
		prod = 20'(v[12:3]) * 20'd683;
		return prod[18:11];
	endfunction

	function automatic sum3_t fade_rgb(input rgb_t p, input rgb_t bg, input logic [4:0] w);
		sum3_t s;
		s.red   = fade_sum(p.red, bg.red, w);
		s.green = fade_sum(p.green, bg.green, w);
		s.blue  = fade_sum(p.blue, bg.blue, w);
		return s;
	endfunction

	function automatic rgb_t div24_rgb(input sum3_t s);
		rgb_t q;
		q.red   = div24(s.red);
		q.green = div24(s.green);
		q.blue  = div24(s.blue);
		return q;
	endfunction

endpackage

FILE: hw/rtl/smef_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the marquee block.
interface smef_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [4:0] row;
	logic [9:0] column;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport src (output valid, operation, row, column, in_red, in_green, in_blue,
		input ready);
	modport snk (input valid, operation, row, column, in_red, in_green, in_blue,
		output ready);
endinterface

interface smef_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport src (output valid, out_red, out_green, out_blue, input ready);
	modport snk (input valid, out_red, out_green, out_blue, output ready);
endinterface

FILE: hw/rtl/smef_queue.sv
`timescale 1ns / 1ps
// Small request FIFO between the front and back halves.
module smef_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			data_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q == rd_ptr_q) |-> (empty || full))
		else $error("queue pointers equal with partial fill");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty right after a push");
`endif

endmodule

FILE: hw/rtl/smef_front.sv
`timescale 1ns / 1ps
// Front half: takes requests, keeps the scroll offset, forms store addresses and fade weights.
module smef_front import smef_pkg::*; #(
	parameter int MAX_TEXT_WIDTH = 1024,
	parameter int MAX_ROWS       = 32,
	parameter int AW             = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	smef_req_if.snk       req,
	input  logic [10:0]   text_width,
	input  logic [10:0]   display_width,
	input  logic          q_full,
	output logic          push,
	output entry_t        push_entry,
	output logic [AW-1:0] push_addr
);
	logic signed [11:0] off_q;
	logic signed [12:0] off_ext;
	logic signed [12:0] tw_ext;
	logic signed [12:0] next_off;
	logic signed [12:0] src_a;
	logic signed [12:0] src_b;
	logic signed [12:0] src_d;
	logic signed [12:0] src;
	logic               accept;
	logic               row_ok;
	logic               col_ok;
	logic               hit;
	logic [AW-1:0]      row_base;
	logic [10:0]        col_ext;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	assign off_ext  = {off_q[11], off_q};
	assign tw_ext   = $signed({2'b00, text_width});
	assign next_off = off_ext + 13'sd1;

	// offset plus column, wrapped once either way
	assign src_a = off_ext + $signed({3'b000, req.column});
	assign src_b = src_a - tw_ext;
	assign src_d = src_a + tw_ext;
	assign src   = !src_b[12] ? src_b : (src_a[12] ? src_d : src_a);

	assign row_ok = 32'(req.row) < MAX_ROWS;
	assign col_ok = 32'(req.column) < MAX_TEXT_WIDTH;
	assign hit    = !src[12] && (32'(src[11:0]) < MAX_TEXT_WIDTH) && row_ok;

	assign row_base = AW'(req.row) * AW'(MAX_TEXT_WIDTH);
	assign col_ext  = {1'b0, req.column};

	always_comb begin
		push_entry.is_read = (req.operation == OP_READ);
		push_entry.hit     = hit;
		push_entry.pixel   = {req.in_red, req.in_green, req.in_blue};
		push_entry.fade_l  = req.column < 10'(FADE_SPAN);
		push_entry.w_l     = req.column[4:0];
		// right fade once column > display_width - 24; weight floors at zero
		push_entry.fade_r  = (col_ext + 11'(FADE_SPAN)) > display_width;
		push_entry.w_r     = (col_ext >= display_width) ? 5'd0 : 5'(display_width - col_ext);
		if (req.operation == OP_READ)
			push_addr = row_base + AW'(src[11:0]);
		else
			push_addr = row_base + AW'(req.column);
	end

	assign push = accept && (((req.operation == OP_WRITE) && row_ok && col_ok) ||
		(req.operation == OP_READ));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= -12'sd1;
		end else if (accept && (req.operation == OP_ADVANCE)) begin
			off_q <= (next_off >= tw_ext) ? 12'sd0 : next_off[11:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_off_floor: assert property (@(posedge clk) disable iff (!arst_n)
		off_q[11] |-> (&off_q))
		else $error("scroll offset below minus one");
	a_adv_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.operation == OP_ADVANCE)) |=> !off_q[11])
		else $error("offset negative after advance");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into full queue");
`endif

endmodule

FILE: hw/rtl/smef_back.sv
`timescale 1ns / 1ps
// Back half: text store, read pipeline and the left and right edge fades.
module smef_back import smef_pkg::*; #(
	parameter int AW        = 15,
	parameter int MEM_DEPTH = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  entry_t        q_entry,
	input  logic [AW-1:0] q_addr,
	output logic          pop,
	input  rgb_t          bg,
	smef_rsp_if.src       rsp
);
	rgb_t       mem_q [MEM_DEPTH];

	logic       en;
	logic       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	rgb_t       rd_s1;
	entry_t     meta_s1;
	rgb_t       px_s2;
	sum3_t      sum_l_s2;
	logic       fade_l_s2;
	logic       fade_r_s2, fade_r_s3, fade_r_s4;
	logic [4:0] w_r_s2, w_r_s3;
	rgb_t       fl_s3, fl_s4;
	sum3_t      sum_r_s4;
	rgb_t       out_s5;
	rgb_t       px_sel;

	// whole pipeline holds while the output register is full and not taken
	assign en  = !valid_s5 || rsp.ready;
	assign pop = en && q_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_entry.is_read)
				rd_s1 <= mem_q[q_addr];
			else
				mem_q[q_addr] <= q_entry.pixel;
		end
	end

	assign px_sel = meta_s1.hit ? rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1   <= q_entry;
			px_s2     <= px_sel;
			sum_l_s2  <= fade_rgb(px_sel, bg, meta_s1.w_l);
			fade_l_s2 <= meta_s1.fade_l;
			fade_r_s2 <= meta_s1.fade_r;
			w_r_s2    <= meta_s1.w_r;
			fl_s3     <= fade_l_s2 ? div24_rgb(sum_l_s2) : px_s2;
			fade_r_s3 <= fade_r_s2;
			w_r_s3    <= w_r_s2;
			sum_r_s4  <= fade_rgb(fl_s3, bg, w_r_s3);
			fl_s4     <= fl_s3;
			fade_r_s4 <= fade_r_s3;
			out_s5    <= fade_r_s4 ? div24_rgb(sum_r_s4) : fl_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop && q_entry.is_read;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign rsp.valid     = valid_s5;
	assign rsp.out_red   = out_s5.red;
	assign rsp.out_green = out_s5.green;
	assign rsp.out_blue  = out_s5.blue;

`ifndef NO_ASSERTIONS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({valid_s1, valid_s2, valid_s3, valid_s4}))
		else $error("pipeline moved while stalled");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s4) |=> valid_s5)
		else $error("read lost before output register");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(out_s5)))
		else $error("waiting response changed or dropped");
`endif

endmodule

FILE: hw/rtl/scrolling_marquee_edge_fade_top.sv
`timescale 1ns / 1ps
// A read request passes through the queue, the store read and the left and right fades before its pixel is given.
// Throughput: one request per cycle while nothing stalls; the single store port and queue pop set that rate.
// Writes and advances give no response; a full 4-entry queue or a held output stalls requests.
// Reset: scroll offset to minus one, registers to defaults, queue and pipeline emptied.
// The text store is not cleared by reset; unwritten pixels read as undefined.
module scrolling_marquee_edge_fade_top import smef_pkg::*; #(
	parameter int MAX_TEXT_WIDTH = 1024,
	parameter int MAX_ROWS       = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	smef_req_if.snk               req,
	smef_rsp_if.src               rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int MEM_DEPTH = MAX_ROWS * MAX_TEXT_WIDTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int EW        = $bits(entry_t);
	localparam int QW        = AW + EW;

	logic [10:0]   tw_q;
	logic [10:0]   dw_q;
	rgb_t          bg_q;

	logic          push;
	entry_t        push_entry;
	logic [AW-1:0] push_addr;
	logic          pop;
	logic [QW-1:0] pop_data;
	logic          q_full;
	logic          q_empty;
	entry_t        q_entry;
	logic [AW-1:0] q_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= TEXT_WIDTH_RST;
			dw_q <= DISPLAY_WIDTH_RST;
			bg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_WIDTH:     tw_q <= cfg_data;
				REG_DISPLAY_WIDTH:  dw_q <= cfg_data;
				REG_DISPLAY_HEIGHT: ; // window height changes no pixel
				REG_BG_RED:         bg_q.red <= cfg_data[7:0];
				REG_BG_GREEN:       bg_q.green <= cfg_data[7:0];
				REG_BG_BLUE:        bg_q.blue <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	smef_front #(
		.MAX_TEXT_WIDTH(MAX_TEXT_WIDTH),
		.MAX_ROWS(MAX_ROWS),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.text_width(tw_q),
		.display_width(dw_q),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry),
		.push_addr(push_addr)
	);

	smef_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_addr, push_entry}),
		.pop(pop),
		.pop_data(pop_data),
		.full(q_full),
		.empty(q_empty)
	);

	assign q_entry = pop_data[EW-1:0];
	assign q_addr  = pop_data[QW-1:EW];

	smef_back #(
		.AW(AW),
		.MEM_DEPTH(MEM_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(!q_empty),
		.q_entry(q_entry),
		.q_addr(q_addr),
		.pop(pop),
		.bg(bg_q),
		.rsp(rsp)
	);

endmodule
